@@ hw/rtl/dvc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value counter package
// Sizes of the table, the counters and the token that moves down the cells.
// ----------------------------------------------------------------------------
package dvc_pkg;

  // Number of table entries, one per cell.
  localparam int unsigned TABLE_DEPTH = 64;
  // Width of each occurrence counter.
  localparam int unsigned COUNT_BITS  = 16;
  // Width of the data values.
  localparam int unsigned VALUE_BITS  = 32;

  // Derived widths.
  localparam int unsigned IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned TOTAL_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // One search request together with the partial result it has gathered.
  typedef struct packed {
    logic                         valid;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
    logic                         found;
    logic                         is_new;
    logic [IDX_W-1:0]             idx;
    logic [COUNT_BITS-1:0]        cnt;
    logic [TOTAL_W-1:0]           total;
  } token_t;

endpackage

@@ hw/rtl/dvc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value counter channels
// Valid/ready channels for the incoming values and the per-value results.
// ----------------------------------------------------------------------------

// Incoming value stream.
interface dvc_in_if
  import dvc_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// Result stream, one transfer per incoming value.
interface dvc_out_if
  import dvc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      entry_index;
  logic                  is_new;
  logic [COUNT_BITS-1:0] entry_count;
  logic [TOTAL_W-1:0]    distinct_total;
  logic                  overflow;
  logic                  seq_end;

  modport source (output valid, output entry_index, output is_new, output entry_count,
                  output distinct_total, output overflow, output seq_end,
                  input ready);
  modport sink   (input valid, input entry_index, input is_new, input entry_count,
                  input distinct_total, input overflow, input seq_end,
                  output ready);
endinterface

@@ hw/rtl/dvc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value counter cell
// Holds one table entry, matches or claims it for a passing token, and
// hands the token on to the next cell through a register.
// ----------------------------------------------------------------------------
module dvc_cell
  import dvc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  token_t           tok_i,
  output token_t           tok_o
);

  logic signed [VALUE_BITS-1:0] value_q;
  logic [COUNT_BITS-1:0]        count_q;
  logic                         occupied_q, occupied_d;
  logic                         tok_valid_q;
  token_t                       tok_d, tok_q;

  logic                  act;
  logic                  hit;
  logic                  claim;
  logic [COUNT_BITS-1:0] count_inc;

  // A held entry matches only if no earlier cell already took the token;
  // the first free cell takes a value that nothing matched.
  assign act       = tok_i.valid && advance_i;
  assign hit       = occupied_q && (value_q == tok_i.value) && !tok_i.found;
  assign claim     = !occupied_q && !tok_i.found;
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_ONE;

  // Partial result handed to the next cell.
  always_comb begin
    tok_d        = tok_i;
    tok_d.found  = tok_i.found | hit | claim;
    tok_d.is_new = tok_i.is_new | claim;
    tok_d.total  = tok_i.total + TOTAL_W'(occupied_q | claim);
    if (hit) begin
      tok_d.idx = cell_idx_i;
      tok_d.cnt = count_inc;
    end else if (claim) begin
      tok_d.idx = cell_idx_i;
      tok_d.cnt = COUNT_ONE;
    end
  end

  // The entry empties once a token that closes the sequence has passed.
  always_comb begin
    occupied_d = occupied_q;
    if (act) begin
      occupied_d = tok_i.last ? 1'b0 : (occupied_q | claim);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied_q  <= 1'b0;
      tok_valid_q <= 1'b0;
    end else begin
      occupied_q <= occupied_d;
      if (advance_i) begin
        tok_valid_q <= tok_i.valid;
      end
    end
  end

  // Entry contents and token payload.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tok_q <= tok_d;
    end
    if (act && hit) begin
      count_q <= count_inc;
    end else if (act && claim) begin
      value_q <= tok_i.value;
      count_q <= COUNT_ONE;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

@@ hw/rtl/distinct_value_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value counter
// Builds a table of distinct values in order of first appearance, with an
// occurrence count for each, and reports one result per incoming value.
// ----------------------------------------------------------------------------
// Usage:
// Values arrive on in_i (value, last) and results leave on out_o, one result
// transfer for each value transfer, in the same order. Each table entry lives
// in its own cell; a value travels down the row of TABLE_DEPTH cells, one
// cell per cycle while the row advances, and the cell that holds it bumps its
// saturating count, or the first free cell takes it with count 1. With no
// cell left the value is dropped and overflow is set. A value marked last
// closes the sequence, and each cell empties as that value passes it.
// Each value passes through the register of every cell in turn; the last
// cell's register is the result register and holds the result until taken.
// The row accepts one value per cycle unless it is stalled, since each
// value sees the cells only after all earlier values have passed them.
// Reset empties the table and drops any values in flight. When the receiver
// stalls with a result waiting, the whole row holds and in_i.ready is low
// until the result is taken.
// ----------------------------------------------------------------------------
module distinct_value_counter
  import dvc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dvc_in_if.sink      in_i,
  dvc_out_if.source   out_o
);

  token_t tok [TABLE_DEPTH+1];
  token_t tok_in;
  logic   advance;

  // The row moves whenever the result register is empty or being taken.
  assign advance  = !tok[TABLE_DEPTH].valid || out_o.ready;
  assign in_i.ready = advance;

  // Fresh token for an incoming value.
  always_comb begin
    tok_in        = '0;
    tok_in.valid  = in_i.valid;
    tok_in.value  = in_i.value;
    tok_in.last   = in_i.last;
  end

  assign tok[0] = tok_in;

  // Row of table cells.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dvc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .cell_idx_i (IDX_W'(g)),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  // The last cell's register is the result register.
  assign out_o.valid          = tok[TABLE_DEPTH].valid;
  assign out_o.entry_index    = tok[TABLE_DEPTH].idx;
  assign out_o.is_new         = tok[TABLE_DEPTH].is_new;
  assign out_o.entry_count    = tok[TABLE_DEPTH].cnt;
  assign out_o.distinct_total = tok[TABLE_DEPTH].total;
  assign out_o.overflow       = !tok[TABLE_DEPTH].found;
  assign out_o.seq_end        = tok[TABLE_DEPTH].last;

endmodule

@@ tb/tb_distinct_value_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distinct value counter testbench
// Drives value streams into the counter and checks every result transfer
// against a cycle-free model of the frequency table. A short table of
// directed values comes first. Then the table is filled until it overflows,
// and random sequences follow. Both sides idle at random, and the result
// side holds off once for a long stretch so that the row fills and stalls
// its input.
// ----------------------------------------------------------------------------
module tb_distinct_value_counter
  import dvc_pkg::*;
();

  localparam int NUM_ROWS       = 16;
  localparam int RANDOM_ITEMS   = 1170;
  localparam int PRESSURE_AT    = 200;
  localparam int HOLD_CYCLES    = 500;
  localparam int WATCHDOG_LIMIT = 4000;

  // One result as the block reports it.
  typedef struct packed {
    logic [IDX_W-1:0]      entry_index;
    logic                  is_new;
    logic [COUNT_BITS-1:0] entry_count;
    logic [TOTAL_W-1:0]    distinct_total;
    logic                  overflow;
    logic                  seq_end;
  } tally_t;

  // One directed value, with its result typed in where it is obvious.
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
    logic                         typed;
    tally_t                       tally;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dvc_in_if  in_if ();
  dvc_out_if out_if ();

  distinct_value_counter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Directed values, starting from an empty table.
  script_row_t script_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 1'b0, 1'b1, '{6'd0, 1'b1, 16'd1, 7'd1, 1'b0, 1'b0}},
    '{32'h8000_0000, 1'b0, 1'b1, '{6'd1, 1'b1, 16'd1, 7'd2, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, '{6'd2, 1'b1, 16'd1, 7'd3, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, '{6'd3, 1'b1, 16'd1, 7'd4, 1'b0, 1'b0}},
    '{32'h0000_0000, 1'b0, 1'b1, '{6'd0, 1'b0, 16'd2, 7'd4, 1'b0, 1'b0}},
    '{32'h8000_0000, 1'b0, 1'b1, '{6'd1, 1'b0, 16'd2, 7'd4, 1'b0, 1'b0}},
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{6'd2, 1'b0, 16'd2, 7'd6, 1'b0, 1'b1}},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, '{6'd0, 1'b1, 16'd1, 7'd1, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'hDEAD_BEEF, 1'b1, 1'b0, '0},
    '{32'h1234_5678, 1'b1, 1'b1, '{6'd0, 1'b1, 16'd1, 7'd1, 1'b0, 1'b1}},
    '{32'h5555_5555, 1'b1, 1'b1, '{6'd0, 1'b1, 16'd1, 7'd1, 1'b0, 1'b1}},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0, '0}
  };

  logic signed [VALUE_BITS-1:0] corner_values [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'h5555_5555
  };

  // Model of the table: values in order of first appearance and their counts.
  logic signed [VALUE_BITS-1:0] held_value [TABLE_DEPTH];
  logic [COUNT_BITS-1:0]        held_count [TABLE_DEPTH];
  int                           held_entries = 0;

  tally_t tally_q [$];
  int     error_count  = 0;
  int     results_seen = 0;
  int     stall_cycles = 0;

  logic burst_mode    = 1'b0;
  logic sender_fast   = 1'b0;
  logic receiver_fast = 1'b0;
  logic hold_on       = 1'b0;

  // Looks the value up, updates the table and forms the result.
  function automatic tally_t tally_value(input logic signed [VALUE_BITS-1:0] value,
                                         input logic last);
    tally_t t;
    int     k;
    int     hit;
    t   = '0;
    hit = -1;
    for (k = 0; k < held_entries; k++) begin
      if (hit < 0 && held_value[k] == value) hit = k;
    end
    if (hit >= 0) begin
      if (held_count[hit] != COUNT_MAX) held_count[hit] = held_count[hit] + 1'b1;
      t.entry_index = IDX_W'(hit);
      t.entry_count = held_count[hit];
    end else if (held_entries < TABLE_DEPTH) begin
      held_value[held_entries] = value;
      held_count[held_entries] = COUNT_ONE;
      t.entry_index = IDX_W'(held_entries);
      t.is_new      = 1'b1;
      t.entry_count = COUNT_ONE;
      held_entries++;
    end else begin
      // Table full: the value is dropped.
      t.overflow = 1'b1;
    end
    t.distinct_total = TOTAL_W'(held_entries);
    t.seq_end        = last;
    // The closing value empties the table once its result is formed.
    if (last) held_entries = 0;
    return t;
  endfunction

  // Offers one value after a random gap and records its result on transfer.
  task automatic send_value(input logic signed [VALUE_BITS-1:0] value, input logic last,
                            input logic typed = 1'b0, input tally_t typed_tally = '0);
    int     gap;
    tally_t predicted;
    if (burst_mode || hold_on || sender_fast) gap = 0;
    else gap = $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    in_if.last  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = tally_value(value, last);
    tally_q.push_back(typed ? typed_tally : predicted);
  endtask

  function automatic void compare_field(input string field, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Checks one result transfer against the oldest outstanding value.
  function automatic void check_tally(input tally_t got);
    tally_t want;
    if (tally_q.size() == 0) begin
      error_count++;
      $display("%0t ns: result transfer with no value outstanding", $time);
      return;
    end
    want = tally_q.pop_front();
    compare_field("entry_index", want.entry_index, got.entry_index);
    compare_field("is_new", want.is_new, got.is_new);
    compare_field("entry_count", want.entry_count, got.entry_count);
    compare_field("distinct_total", want.distinct_total, got.distinct_total);
    compare_field("overflow", want.overflow, got.overflow);
    compare_field("seq_end", want.seq_end, got.seq_end);
  endfunction

  // Result side: random stalls, one long hold-off, and a check per transfer.
  initial begin
    int gap;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (results_seen == PRESSURE_AT) begin
        hold_on      <= 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on      <= 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) receiver_fast = !receiver_fast;
        gap = (burst_mode || receiver_fast) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      check_tally('{out_if.entry_index, out_if.is_new, out_if.entry_count,
                    out_if.distinct_total, out_if.overflow, out_if.seq_end});
      results_seen++;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("distinct_value_counter: mismatch");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    logic signed [VALUE_BITS-1:0] pool [$];
    logic signed [VALUE_BITS-1:0] v;
    logic                         l;
    int                           r;
    int                           k;
    int                           kind;
    int                           psize;
    int                           len;
    int                           random_sent;
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.last  = 1'b0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed values.
    for (r = 0; r < NUM_ROWS; r++)
      send_value(script_rows[r].value, script_rows[r].last, script_rows[r].typed,
                 script_rows[r].tally);

    // Fill every entry, then drop new values, hit a held one, and close on a drop.
    burst_mode = 1'b1;
    for (k = 0; k < TABLE_DEPTH; k++) send_value((k * 32'h0101_0107) ^ 32'h4000_0000, 1'b0);
    send_value(32'h6BAD_F00D, 1'b0);
    send_value(((TABLE_DEPTH - 1) * 32'h0101_0107) ^ 32'h4000_0000, 1'b0);
    send_value(32'h6BAD_F00E, 1'b1);
    burst_mode = 1'b0;

    // Random sequences: mostly well formed, some without a closing value.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      kind        = $urandom_range(0, 99);
      sender_fast = ($urandom_range(0, 4) == 0);
      pool.delete();
      if (kind < 45) begin
        psize = $urandom_range(1, 12);
        len   = $urandom_range(1, 40);
      end else if (kind < 65) begin
        psize = $urandom_range(70, 90);
        len   = psize + $urandom_range(0, 30);
      end else begin
        psize = 0;
        len   = (kind < 80) ? $urandom_range(1, 8) : $urandom_range(1, 30);
      end
      for (k = 0; k < psize; k++) begin
        if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 15) - 8;
        else v = $urandom;
        pool.push_back(v);
      end
      for (k = 0; k < len; k++) begin
        if (kind < 45) v = pool[$urandom_range(0, psize - 1)];
        else if (kind < 65)
          v = (k < psize && $urandom_range(0, 7) != 0) ? pool[k]
                                                       : pool[$urandom_range(0, psize - 1)];
        else if (kind < 80) v = corner_values[$urandom_range(0, 7)];
        else v = $urandom;
        // Noise sequences carry the closing flag at random.
        if (kind >= 90) l = ($urandom_range(0, 7) == 0);
        else l = (k == len - 1);
        send_value(v, l);
        random_sent++;
      end
    end

    in_if.valid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (2 * TABLE_DEPTH) @(posedge clk_i);
    if (error_count == 0) begin
      $display("distinct_value_counter: match");
    end else begin
      $display("distinct_value_counter: mismatch");
    end
    $finish;
  end

endmodule
